// ----- sv/dtio_pkg.sv -----
// ----------------------------------------------------------------------------
// dtio_pkg
// Shared types, constants and a bcd helper function for the dual timer / time-of-day I/O core.
// ----------------------------------------------------------------------------
package dtio_pkg;

    localparam int StartDelayADefault = 4;
    localparam int StartDelayBDefault = 2;

    typedef enum logic [2:0] {
        FN_READ    = 3'd0,
        FN_WRITE   = 3'd1,
        FN_CLOCK   = 3'd2,
        FN_TOD     = 3'd3,
        FN_PRESS   = 3'd4,
        FN_RELEASE = 3'd5,
        FN_NOP6    = 3'd6,
        FN_NOP7    = 3'd7
    } func_t;

    localparam logic [3:0] REG_PRA  = 4'd0;
    localparam logic [3:0] REG_PRB  = 4'd1;
    localparam logic [3:0] REG_DDRA = 4'd2;
    localparam logic [3:0] REG_DDRB = 4'd3;
    localparam logic [3:0] REG_TALO = 4'd4;
    localparam logic [3:0] REG_TAHI = 4'd5;
    localparam logic [3:0] REG_TBLO = 4'd6;
    localparam logic [3:0] REG_TBHI = 4'd7;
    localparam logic [3:0] REG_TEN  = 4'd8;
    localparam logic [3:0] REG_SEC  = 4'd9;
    localparam logic [3:0] REG_MIN  = 4'd10;
    localparam logic [3:0] REG_HR   = 4'd11;
    localparam logic [3:0] REG_SDR  = 4'd12;
    localparam logic [3:0] REG_ICR  = 4'd13;
    localparam logic [3:0] REG_CRA  = 4'd14;
    localparam logic [3:0] REG_CRB  = 4'd15;

    localparam logic [1:0] CFG_KEYBOARD = 2'd0;
    localparam logic [1:0] CFG_EXT_A    = 2'd1;
    localparam logic [1:0] CFG_EXT_B    = 2'd2;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
        logic [2:0] key_row;
        logic [2:0] key_col;
    } in_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
        logic [7:0] port_a_drive;
        logic [7:0] port_b_drive;
        logic       timer_a_toggle;
        logic       timer_b_toggle;
    } out_item_t;

    typedef struct packed {
        logic [7:0] hr;
        logic [6:0] min;
        logic [6:0] sec;
        logic [3:0] ten;
    } tod_t;

    // bcd increment of one byte
    function automatic logic [7:0] bcd_inc(input logic [7:0] v);
        logic [7:0] s;
        begin
            s = v + 8'd1;
            if (s[3:0] >= 4'd10) begin
                s = {s[7:4], 4'd0} + 8'h10;
            end
            return s;
        end
    endfunction

endpackage

// ----- sv/dual_timer_tod_io_interface_core.sv -----
// ----------------------------------------------------------------------------
// dual_timer_tod_io_interface_core
// Register-mapped dual timer, bcd time-of-day clock, ports and key matrix.
// ----------------------------------------------------------------------------
// result: registered; the result register loads as the input beat is accepted
// throughput: one item per cycle while results are taken; the result register frees as it is taken
// state update and result are computed in one pass over the stored registers
// reset: synchronous active-low aresetn returns all registers but the result data to power-up values
module dual_timer_tod_io_interface_core
    import dtio_pkg::*;
#(
    parameter int START_DELAY_A = StartDelayADefault,
    parameter int START_DELAY_B = StartDelayBDefault
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data
);

    logic kbd_reg, exta_reg, extb_reg;
    logic [7:0] pra_reg, prb_reg, ddra_reg, ddrb_reg;
    logic [15:0] cnta_reg, rlda_reg, cntb_reg, rldb_reg;
    logic runa_reg, runb_reg;
    logic [2:0] dlya_reg;
    logic [1:0] dlyb_reg;
    logic tga_reg, tgb_reg;
    logic [7:0] cra_reg, crb_reg, sdr_reg;
    tod_t tod_reg, alarm_reg, frz_reg;
    logic frozen_reg, halted_reg;
    logic [4:0] flags_reg, mask_reg;
    logic irq_reg;
    logic [7:0] keys_reg [8];
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    logic accept;
    tod_t tod_inc;

    assign s_ready   = ~m_valid_reg | m_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    dtio_tod u_tod (.cur(tod_reg), .nxt(tod_inc));

    // configuration bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kbd_reg  <= 1'b1;
            exta_reg <= 1'b0;
            extb_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEYBOARD: kbd_reg  <= cfg_data;
                CFG_EXT_A:    exta_reg <= cfg_data;
                CFG_EXT_B:    extb_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next state and result for one item
    logic kbd_n;
    logic [7:0] pra_next, prb_next, ddra_next, ddrb_next, cra_next, crb_next, sdr_next;
    logic [15:0] cnta_next, rlda_next, cntb_next, rldb_next;
    logic runa_next, runb_next, tga_next, tgb_next, frozen_next, halted_next, irq_next;
    logic [2:0] dlya_next;
    logic [1:0] dlyb_next;
    tod_t tod_next, alarm_next, frz_next;
    logic [4:0] flags_next, mask_next;
    logic [7:0] rd;
    logic [7:0] scan;

    assign kbd_n = kbd_reg;

    always_comb begin
        scan = 8'hFF;
        for (int c = 0; c < 8; c++) begin
            if (!pra_reg[c]) scan = scan & keys_reg[c];
        end
    end

    always_comb begin
        logic und_a;
        logic cnt_b;
        logic [15:0] rl;
        pra_next = pra_reg;   prb_next = prb_reg;
        ddra_next = ddra_reg; ddrb_next = ddrb_reg;
        cnta_next = cnta_reg; rlda_next = rlda_reg;
        cntb_next = cntb_reg; rldb_next = rldb_reg;
        runa_next = runa_reg; runb_next = runb_reg;
        dlya_next = dlya_reg; dlyb_next = dlyb_reg;
        tga_next = tga_reg;   tgb_next = tgb_reg;
        cra_next = cra_reg;   crb_next = crb_reg;
        sdr_next = sdr_reg;
        tod_next = tod_reg;   alarm_next = alarm_reg; frz_next = frz_reg;
        frozen_next = frozen_reg; halted_next = halted_reg;
        flags_next = flags_reg; mask_next = mask_reg; irq_next = irq_reg;
        rd = 8'hFF;
        und_a = 1'b0;
        cnt_b = 1'b0;
        rl = 16'd0;
        unique case (func_t'(s_data.func))
            FN_READ: begin
                unique case (s_data.reg_addr)
                    REG_PRA: rd = exta_reg
                        ? ((pra_reg & ddra_reg) | (s_data.port_a_pins & ~ddra_reg))
                        : (pra_reg | ~ddra_reg);
                    REG_PRB: begin
                        if (extb_reg)
                            rd = (prb_reg & ddrb_reg) | (s_data.port_b_pins & ~ddrb_reg);
                        else if (kbd_n) rd = scan;
                        else rd = prb_reg | ~ddrb_reg;
                    end
                    REG_DDRA: rd = ddra_reg;
                    REG_DDRB: rd = ddrb_reg;
                    REG_TALO: rd = cnta_reg[7:0];
                    REG_TAHI: rd = cnta_reg[15:8];
                    REG_TBLO: rd = cntb_reg[7:0];
                    REG_TBHI: rd = cntb_reg[15:8];
                    REG_TEN: begin
                        rd = {4'd0, frozen_reg ? frz_reg.ten : tod_reg.ten};
                        frozen_next = 1'b0;
                    end
                    REG_SEC: rd = {1'b0, frozen_reg ? frz_reg.sec : tod_reg.sec};
                    REG_MIN: rd = {1'b0, frozen_reg ? frz_reg.min : tod_reg.min};
                    REG_HR: begin
                        if (!frozen_reg) begin
                            frozen_next = 1'b1;
                            frz_next = tod_reg;
                            rd = tod_reg.hr;
                        end else begin
                            rd = frz_reg.hr;
                        end
                    end
                    REG_SDR: rd = sdr_reg;
                    REG_ICR: begin
                        rd = {irq_reg, 2'd0, flags_reg};
                        flags_next = 5'd0;
                        irq_next = 1'b0;
                    end
                    REG_CRA: rd = cra_reg;
                    REG_CRB: rd = crb_reg;
                    default: rd = crb_reg;
                endcase
            end
            FN_WRITE: begin
                unique case (s_data.reg_addr)
                    REG_PRA:  pra_next = s_data.write_data;
                    REG_PRB:  prb_next = s_data.write_data;
                    REG_DDRA: ddra_next = s_data.write_data;
                    REG_DDRB: ddrb_next = s_data.write_data;
                    REG_TALO: rlda_next = {rlda_reg[15:8], s_data.write_data};
                    REG_TAHI: begin
                        rl = {s_data.write_data, rlda_reg[7:0]};
                        rlda_next = rl;
                        if (!cra_reg[0]) cnta_next = rl;
                    end
                    REG_TBLO: rldb_next = {rldb_reg[15:8], s_data.write_data};
                    REG_TBHI: begin
                        rl = {s_data.write_data, rldb_reg[7:0]};
                        rldb_next = rl;
                        if (!crb_reg[0]) cntb_next = rl;
                    end
                    REG_TEN: begin
                        if (crb_reg[7]) alarm_next.ten = s_data.write_data[3:0];
                        else begin
                            tod_next.ten = s_data.write_data[3:0];
                            halted_next = 1'b0;
                        end
                    end
                    REG_SEC: begin
                        if (crb_reg[7]) alarm_next.sec = s_data.write_data[6:0];
                        else tod_next.sec = s_data.write_data[6:0];
                    end
                    REG_MIN: begin
                        if (crb_reg[7]) alarm_next.min = s_data.write_data[6:0];
                        else tod_next.min = s_data.write_data[6:0];
                    end
                    REG_HR: begin
                        if (crb_reg[7]) alarm_next.hr = s_data.write_data & 8'h9F;
                        else begin
                            tod_next.hr = s_data.write_data & 8'h9F;
                            halted_next = 1'b1;
                        end
                    end
                    REG_SDR: sdr_next = s_data.write_data;
                    REG_ICR: begin
                        if (s_data.write_data[7])
                            mask_next = mask_reg | s_data.write_data[4:0];
                        else
                            mask_next = mask_reg & ~s_data.write_data[4:0];
                        if ((flags_reg & mask_next) != 5'd0) irq_next = 1'b1;
                    end
                    REG_CRA: begin
                        cra_next = s_data.write_data;
                        if (s_data.write_data[4]) cnta_next = rlda_reg;
                        if (!runa_reg && s_data.write_data[0])
                            dlya_next = 3'(START_DELAY_A);
                        runa_next = s_data.write_data[0];
                    end
                    default: begin
                        crb_next = s_data.write_data;
                        if (s_data.write_data[4]) cntb_next = rldb_reg;
                        if (!runb_reg && s_data.write_data[0])
                            dlyb_next = 2'(START_DELAY_B);
                        runb_next = s_data.write_data[0];
                    end
                endcase
            end
            FN_CLOCK: begin
                if (runa_reg) begin
                    if (dlya_reg != 3'd0) dlya_next = dlya_reg - 3'd1;
                    else if (cnta_reg == 16'd0) begin
                        und_a = 1'b1;
                        flags_next[0] = 1'b1;
                        cnta_next = rlda_reg;
                        if (cra_reg[2:1] == 2'b11) tga_next = ~tga_reg;
                        if (cra_reg[3]) begin
                            runa_next = 1'b0;
                            cra_next[0] = 1'b0;
                        end
                    end else cnta_next = cnta_reg - 16'd1;
                end
                if (runb_reg) begin
                    if (dlyb_reg != 2'd0) dlyb_next = dlyb_reg - 2'd1;
                    else begin
                        cnt_b = crb_reg[6] ? und_a : 1'b1;
                        if (cnt_b) begin
                            if (cntb_reg == 16'd0) begin
                                flags_next[1] = 1'b1;
                                cntb_next = rldb_reg;
                                if (crb_reg[2:1] == 2'b11) tgb_next = ~tgb_reg;
                                if (crb_reg[3]) begin
                                    runb_next = 1'b0;
                                    crb_next[0] = 1'b0;
                                end
                            end else cntb_next = cntb_reg - 16'd1;
                        end
                    end
                end
                if ((flags_next & mask_reg) != 5'd0) irq_next = 1'b1;
            end
            FN_TOD: begin
                if (!halted_reg) begin
                    if (tod_reg == alarm_reg) flags_next[2] = 1'b1;
                    tod_next = tod_inc;
                    if ((flags_next & mask_reg) != 5'd0) irq_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // key matrix update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 8; c++) keys_reg[c] <= 8'hFF;
        end else if (accept) begin
            if (s_data.func == FN_PRESS)
                keys_reg[s_data.key_col][s_data.key_row] <= 1'b0;
            else if (s_data.func == FN_RELEASE)
                keys_reg[s_data.key_col][s_data.key_row] <= 1'b1;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pra_reg <= 8'hFF; prb_reg <= 8'hFF; ddra_reg <= 8'hFF; ddrb_reg <= 8'hFF;
            cnta_reg <= 16'hFFFF; rlda_reg <= 16'hFFFF;
            cntb_reg <= 16'hFFFF; rldb_reg <= 16'hFFFF;
            runa_reg <= 1'b0; runb_reg <= 1'b0; dlya_reg <= 3'd0; dlyb_reg <= 2'd0;
            tga_reg <= 1'b0; tgb_reg <= 1'b0; cra_reg <= 8'd0; crb_reg <= 8'd0;
            sdr_reg <= 8'd0;
            tod_reg <= '{hr: 8'h01, min: 7'd0, sec: 7'd0, ten: 4'd0};
            alarm_reg <= '0; frz_reg <= '0;
            frozen_reg <= 1'b0; halted_reg <= 1'b0;
            flags_reg <= 5'd0; mask_reg <= 5'd0; irq_reg <= 1'b0;
        end else if (accept) begin
            pra_reg <= pra_next; prb_reg <= prb_next;
            ddra_reg <= ddra_next; ddrb_reg <= ddrb_next;
            cnta_reg <= cnta_next; rlda_reg <= rlda_next;
            cntb_reg <= cntb_next; rldb_reg <= rldb_next;
            runa_reg <= runa_next; runb_reg <= runb_next;
            dlya_reg <= dlya_next; dlyb_reg <= dlyb_next;
            tga_reg <= tga_next; tgb_reg <= tgb_next;
            cra_reg <= cra_next; crb_reg <= crb_next; sdr_reg <= sdr_next;
            tod_reg <= tod_next; alarm_reg <= alarm_next; frz_reg <= frz_next;
            frozen_reg <= frozen_next; halted_reg <= halted_next;
            flags_reg <= flags_next; mask_reg <= mask_next; irq_reg <= irq_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg.read_data      <= rd;
            m_data_reg.irq_out        <= irq_next;
            m_data_reg.port_a_drive   <= pra_next & ddra_next;
            m_data_reg.port_b_drive   <= prb_next & ddrb_next;
            m_data_reg.timer_a_toggle <= tga_next;
            m_data_reg.timer_b_toggle <= tgb_next;
        end
    end

endmodule

// ----- sv/dtio_tod.sv -----
// ----------------------------------------------------------------------------
// dtio_tod
// Next-value logic of the bcd time-of-day clock for one tick.
// ----------------------------------------------------------------------------
module dtio_tod
    import dtio_pkg::*;
(
    input  tod_t cur,
    output tod_t nxt
);

    // tenths, seconds, minutes, hours carry chain
    always_comb begin
        logic [7:0] sec8;
        logic [7:0] min8;
        logic [7:0] hr8;
        logic       pm;
        nxt  = cur;
        sec8 = {1'b0, cur.sec};
        min8 = {1'b0, cur.min};
        hr8  = cur.hr;
        pm   = cur.hr[7];
        if (cur.ten + 4'd1 >= 4'd10 || cur.ten == 4'hF) begin
            nxt.ten = 4'd0;
            sec8 = bcd_inc(sec8);
            if (sec8 >= 8'h60) begin
                sec8 = 8'd0;
                min8 = bcd_inc(min8);
                if (min8 >= 8'h60) begin
                    min8 = 8'd0;
                    hr8 = bcd_inc({3'd0, cur.hr[4:0]});
                    if (hr8 >= 8'h12) begin
                        if (hr8 == 8'h12) pm = ~pm;
                        else hr8 = 8'h01;
                    end
                    hr8 = hr8 | {pm, 7'd0};
                end
            end
        end else begin
            nxt.ten = cur.ten + 4'd1;
        end
        nxt.sec = sec8[6:0];
        nxt.min = min8[6:0];
        nxt.hr  = hr8;
    end

endmodule

// ----- verif/tb_dual_timer_tod_io_interface_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_timer_tod_io_interface_core
// Drives register, timer, time-of-day and key items into the core and checks
// every result beat against a cycle-free behavioral model of the peripheral.
// ----------------------------------------------------------------------------
module tb_dual_timer_tod_io_interface_core;
    import dtio_pkg::*;

    // behavioral model of the peripheral plus the queue of predicted beats
    class periph_scoreboard;
        bit kbd, ext_a, ext_b;
        bit [7:0] pra, prb, ddra, ddrb;
        bit [15:0] cnt_a, rel_a, cnt_b, rel_b;
        bit run_a, run_b, tog_a, tog_b;
        bit [2:0] dly_a;
        bit [1:0] dly_b;
        bit [7:0] cra, crb, sdr;
        tod_t tod, alarm, latch;
        bit latched, halted, irq;
        bit [4:0] flags, mask;
        bit [7:0] keys [8];
        out_item_t pending_beats [$];
        int errors;

        function void reset_state();
            kbd = 1; ext_a = 0; ext_b = 0;
            pra = 8'hFF; prb = 8'hFF; ddra = 8'hFF; ddrb = 8'hFF;
            cnt_a = 16'hFFFF; rel_a = 16'hFFFF; cnt_b = 16'hFFFF; rel_b = 16'hFFFF;
            run_a = 0; run_b = 0; tog_a = 0; tog_b = 0; dly_a = 0; dly_b = 0;
            cra = 0; crb = 0; sdr = 0;
            tod = '0; tod.hr = 8'h01; alarm = '0; latch = '0;
            latched = 0; halted = 0; irq = 0; flags = 0; mask = 0;
            foreach (keys[i]) keys[i] = 8'hFF;
        endfunction

        function void set_cfg(bit [1:0] idx, bit v);
            if (idx == CFG_KEYBOARD) kbd = v;
            else if (idx == CFG_EXT_A) ext_a = v;
            else if (idx == CFG_EXT_B) ext_b = v;
        endfunction

        function bit [7:0] inc_bcd(bit [7:0] v);
            bit [7:0] s;
            s = v + 8'd1;
            if (s[3:0] >= 4'd10) s = {s[7:4], 4'd0} + 8'h10;
            return s;
        endfunction

        function bit [7:0] tod_part(tod_t t, int p);
            case (p)
                0: return {4'd0, t.ten};
                1: return {1'b0, t.sec};
                2: return {1'b0, t.min};
                default: return t.hr;
            endcase
        endfunction

        function bit [7:0] reg_read(bit [3:0] a, bit [7:0] pa, bit [7:0] pb);
            bit [7:0] r;
            case (a)
                REG_PRA: return ext_a ? ((pra & ddra) | (pa & ~ddra)) : (pra | ~ddra);
                REG_PRB: begin
                    if (ext_b) return (prb & ddrb) | (pb & ~ddrb);
                    if (kbd) begin
                        r = 8'hFF;
                        for (int c = 0; c < 8; c++) if (!pra[c]) r &= keys[c];
                        return r;
                    end
                    return prb | ~ddrb;
                end
                REG_DDRA: return ddra;
                REG_DDRB: return ddrb;
                REG_TALO: return cnt_a[7:0];
                REG_TAHI: return cnt_a[15:8];
                REG_TBLO: return cnt_b[7:0];
                REG_TBHI: return cnt_b[15:8];
                REG_TEN: begin
                    if (latched) begin
                        latched = 0;
                        return tod_part(latch, 0);
                    end
                    return tod_part(tod, 0);
                end
                REG_SEC: return tod_part(latched ? latch : tod, 1);
                REG_MIN: return tod_part(latched ? latch : tod, 2);
                REG_HR: begin
                    if (!latched) begin
                        latched = 1;
                        latch = tod;
                    end
                    return latch.hr;
                end
                REG_SDR: return sdr;
                REG_ICR: begin
                    r = {irq, 2'b00, flags};
                    flags = 0; irq = 0;
                    return r;
                end
                REG_CRA: return cra;
                default: return crb;
            endcase
        endfunction

        function void reg_write(bit [3:0] a, bit [7:0] d);
            bit alm;
            alm = crb[7];
            case (a)
                REG_PRA: pra = d;
                REG_PRB: prb = d;
                REG_DDRA: ddra = d;
                REG_DDRB: ddrb = d;
                REG_TALO: rel_a[7:0] = d;
                REG_TAHI: begin
                    rel_a[15:8] = d;
                    if (!cra[0]) cnt_a = rel_a;
                end
                REG_TBLO: rel_b[7:0] = d;
                REG_TBHI: begin
                    rel_b[15:8] = d;
                    if (!crb[0]) cnt_b = rel_b;
                end
                REG_TEN: begin
                    if (alm) alarm.ten = d[3:0];
                    else begin
                        tod.ten = d[3:0];
                        halted = 0;
                    end
                end
                REG_SEC: if (alm) alarm.sec = d[6:0]; else tod.sec = d[6:0];
                REG_MIN: if (alm) alarm.min = d[6:0]; else tod.min = d[6:0];
                REG_HR: begin
                    if (alm) alarm.hr = d & 8'h9F;
                    else begin
                        tod.hr = d & 8'h9F;
                        halted = 1;
                    end
                end
                REG_SDR: sdr = d;
                REG_ICR: begin
                    if (d[7]) mask |= d[4:0]; else mask &= ~d[4:0];
                    if (flags & mask) irq = 1;
                end
                REG_CRA: begin
                    cra = d;
                    if (d[4]) cnt_a = rel_a;
                    if (!run_a && d[0]) dly_a = 3'(StartDelayADefault);
                    run_a = d[0];
                end
                default: begin
                    crb = d;
                    if (d[4]) cnt_b = rel_b;
                    if (!run_b && d[0]) dly_b = 2'(StartDelayBDefault);
                    run_b = d[0];
                end
            endcase
        endfunction

        function void timer_tick();
            bit under_a;
            under_a = 0;
            if (run_a) begin
                if (dly_a > 0) dly_a--;
                else if (cnt_a == 0) begin
                    under_a = 1;
                    flags[0] = 1;
                    cnt_a = rel_a;
                    if (cra[2:1] == 2'b11) tog_a ^= 1;
                    if (cra[3]) begin
                        run_a = 0;
                        cra[0] = 0;
                    end
                end else cnt_a--;
            end
            if (run_b) begin
                if (dly_b > 0) dly_b--;
                else if (crb[6] ? under_a : 1'b1) begin
                    if (cnt_b == 0) begin
                        flags[1] = 1;
                        cnt_b = rel_b;
                        if (crb[2:1] == 2'b11) tog_b ^= 1;
                        if (crb[3]) begin
                            run_b = 0;
                            crb[0] = 0;
                        end
                    end else cnt_b--;
                end
            end
            if (flags & mask) irq = 1;
        endfunction

        function void tod_tick();
            bit [7:0] ten, sec, mins, hr;
            bit pm;
            if (halted) return;
            if (tod == alarm) flags[2] = 1;
            ten = tod.ten; sec = tod.sec; mins = tod.min; hr = tod.hr;
            ten++;
            if (ten >= 10) begin
                ten = 0;
                sec = inc_bcd(sec);
                if (sec >= 8'h60) begin
                    sec = 0;
                    mins = inc_bcd(mins);
                    if (mins >= 8'h60) begin
                        mins = 0;
                        pm = hr[7];
                        hr = inc_bcd(hr & 8'h1F);
                        if (hr >= 8'h12) begin
                            if (hr == 8'h12) pm = !pm;
                            else hr = 8'h01;
                        end
                        hr = hr | (pm ? 8'h80 : 8'h00);
                    end
                end
            end
            tod.ten = ten[3:0]; tod.sec = sec[6:0]; tod.min = mins[6:0]; tod.hr = hr;
            if (flags & mask) irq = 1;
        endfunction

        function void note_input(in_item_t it);
            out_item_t o;
            o.read_data = 8'hFF;
            case (func_t'(it.func))
                FN_READ: o.read_data = reg_read(it.reg_addr, it.port_a_pins, it.port_b_pins);
                FN_WRITE: reg_write(it.reg_addr, it.write_data);
                FN_CLOCK: timer_tick();
                FN_TOD: tod_tick();
                FN_PRESS: keys[it.key_col][it.key_row] = 0;
                FN_RELEASE: keys[it.key_col][it.key_row] = 1;
                default: ;
            endcase
            o.irq_out = irq;
            o.port_a_drive = pra & ddra;
            o.port_b_drive = prb & ddrb;
            o.timer_a_toggle = tog_a;
            o.timer_b_toggle = tog_b;
            pending_beats.push_back(o);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing predicted");
                errors++;
                return;
            end
            e = pending_beats.pop_front();
            if (got.read_data !== e.read_data) begin
                $error("read_data exp %h got %h", e.read_data, got.read_data); errors++;
            end
            if (got.irq_out !== e.irq_out) begin
                $error("irq_out exp %b got %b", e.irq_out, got.irq_out); errors++;
            end
            if (got.port_a_drive !== e.port_a_drive) begin
                $error("port_a_drive exp %h got %h", e.port_a_drive, got.port_a_drive);
                errors++;
            end
            if (got.port_b_drive !== e.port_b_drive) begin
                $error("port_b_drive exp %h got %h", e.port_b_drive, got.port_b_drive);
                errors++;
            end
            if (got.timer_a_toggle !== e.timer_a_toggle) begin
                $error("timer_a_toggle exp %b got %b", e.timer_a_toggle, got.timer_a_toggle);
                errors++;
            end
            if (got.timer_b_toggle !== e.timer_b_toggle) begin
                $error("timer_b_toggle exp %b got %b", e.timer_b_toggle, got.timer_b_toggle);
                errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready;
    in_item_t s_data;
    out_item_t m_data;
    logic cfg_valid, cfg_ready, cfg_data;
    logic [1:0] cfg_index;

    periph_scoreboard sb;
    int send_idle_pct, recv_idle_pct;
    bit hold_off;

    dual_timer_tod_io_interface_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random ready, long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // one input beat; valid held until accepted, dropped only on idle cycles
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(it);
        @(negedge aclk);
    endtask

    task automatic write_cfg(bit [1:0] idx, bit v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_cfg(idx, v);
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending_beats.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic in_item_t make_item(func_t f, bit [3:0] a, bit [7:0] d);
        in_item_t it;
        it.func = f;
        it.reg_addr = a;
        it.write_data = d;
        it.port_a_pins = 8'($urandom);
        it.port_b_pins = 8'($urandom);
        it.key_row = 3'($urandom);
        it.key_col = 3'($urandom);
        return it;
    endfunction

    // random item weighted toward timer and clock activity
    function automatic in_item_t rand_item();
        int p;
        bit [3:0] a;
        bit [7:0] d;
        p = $urandom_range(99);
        a = 4'($urandom);
        d = 8'($urandom);
        if (p < 25) return make_item(FN_READ, a, d);
        if (p < 45) begin
            // keep timer reloads small so underflows happen
            if (a == REG_TAHI || a == REG_TBHI) d = ($urandom_range(9) == 0) ? d : 8'h00;
            if ((a == REG_TALO || a == REG_TBLO) && $urandom_range(1)) d = d & 8'h07;
            return make_item(FN_WRITE, a, d);
        end
        if (p < 75) return make_item(FN_CLOCK, a, d);
        if (p < 87) return make_item(FN_TOD, a, d);
        if (p < 92) return make_item(FN_PRESS, a, d);
        if (p < 97) return make_item(FN_RELEASE, a, d);
        return make_item(func_t'(3'($urandom_range(7, 6))), a, d);
    endfunction

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++) send_item(rand_item());
        drain();
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // directed: reset readback, keys, near-rollover clock, timers
        for (int r = 0; r < 16; r++) send_item(make_item(FN_READ, 4'(r), 8'h00));
        send_item(make_item(FN_PRESS, REG_PRA, 8'h00));
        send_item(make_item(FN_WRITE, REG_PRA, 8'h00));
        send_item(make_item(FN_READ, REG_PRB, 8'h00));
        send_item(make_item(FN_WRITE, REG_CRB, 8'h00));
        send_item(make_item(FN_WRITE, REG_HR, 8'h91));
        send_item(make_item(FN_WRITE, REG_MIN, 8'h59));
        send_item(make_item(FN_WRITE, REG_SEC, 8'h59));
        send_item(make_item(FN_WRITE, REG_TEN, 8'h09));
        send_item(make_item(FN_TOD, REG_PRA, 8'h00));
        send_item(make_item(FN_WRITE, REG_ICR, 8'h9F));
        send_item(make_item(FN_WRITE, REG_TAHI, 8'h00));
        send_item(make_item(FN_WRITE, REG_CRA, 8'h1F));
        repeat (8) send_item(make_item(FN_CLOCK, REG_PRA, 8'h00));
        send_item(make_item(FN_READ, REG_ICR, 8'h00));
        send_item(make_item(FN_NOP7, REG_PRA, 8'h00));
        drain();

        // pressure: receiver stalls long while inputs keep coming
        fork
            begin
                hold_off = 1;
                repeat (60) @(negedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 30; i++) send_item(rand_item());
        join
        drain();

        send_idle_pct = 19; recv_idle_pct = 62;
        write_cfg(CFG_KEYBOARD, 0);
        write_cfg(CFG_EXT_A, 1);
        write_cfg(CFG_EXT_B, 1);
        run_phase(200);

        send_idle_pct = 62; recv_idle_pct = 19;
        write_cfg(CFG_EXT_B, 0);
        write_cfg(CFG_EXT_A, 0);
        run_phase(200);

        send_idle_pct = 0; recv_idle_pct = 0;
        write_cfg(CFG_KEYBOARD, 1);
        write_cfg(CFG_EXT_A, 1);
        run_phase(200);

        if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- dual_timer_tod_io_interface_core.f -----
sv/dtio_pkg.sv
sv/dtio_tod.sv
sv/dual_timer_tod_io_interface_core.sv
verif/tb_dual_timer_tod_io_interface_core.sv
